// ===== hdl/vbt_pkg.sv =====
package vbt_pkg;

  localparam int DIM_W       = 16;
  localparam int BRICK_SIZE  = 256;
  localparam int OVERLAP     = 2;
  localparam int BRICK_LOG   = $clog2(BRICK_SIZE);
  localparam int TEX_W       = 9;
  localparam int CFG_IDX_W   = 2;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_SIZE = 2'd0,
    REG_Y_SIZE = 2'd1,
    REG_Z_SIZE = 2'd2
  } vbt_reg_t;

  typedef struct packed {
    logic             brick_valid;
    logic [DIM_W-1:0] x_lo;
    logic [DIM_W-1:0] x_hi;
    logic [DIM_W-1:0] y_lo;
    logic [DIM_W-1:0] y_hi;
    logic [DIM_W-1:0] z_lo;
    logic [DIM_W-1:0] z_hi;
    logic [TEX_W-1:0] tex_x;
    logic [TEX_W-1:0] tex_y;
    logic [TEX_W-1:0] tex_z;
    logic             last_brick;
  } vbt_brick_t;

  // one axis of a brick: effective end, texture extent, wrap to next row
  typedef struct packed {
    logic [DIM_W-1:0] stop;
    logic [TEX_W-1:0] extent;
    logic             wrap;
  } vbt_axis_t;

endpackage

// ===== hdl/vbt_if.sv =====
interface vbt_req_if;
  import vbt_pkg::*;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface vbt_cfg_if;
  import vbt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface vbt_brick_if;
  import vbt_pkg::*;
  logic             valid;
  logic             ready;
  logic             brick_valid;
  logic [DIM_W-1:0] x_lo;
  logic [DIM_W-1:0] x_hi;
  logic [DIM_W-1:0] y_lo;
  logic [DIM_W-1:0] y_hi;
  logic [DIM_W-1:0] z_lo;
  logic [DIM_W-1:0] z_hi;
  logic [TEX_W-1:0] tex_x;
  logic [TEX_W-1:0] tex_y;
  logic [TEX_W-1:0] tex_z;
  logic             last_brick;
  modport source (
    output valid, input ready,
    output brick_valid, x_lo, x_hi, y_lo, y_hi,
    output z_lo, z_hi, tex_x, tex_y,
    output tex_z, last_brick
  );
  modport sink (
    input valid, output ready,
    input brick_valid, x_lo, x_hi, y_lo, y_hi,
    input z_lo, z_hi, tex_x, tex_y,
    input tex_z, last_brick
  );
endinterface

// ===== hdl/volume_brick_tiler_core.sv =====
// an accepted request word goes into the result register, or into the skid register if
// that one is held; throughput one word per cycle while the skid register is empty, set by
// the single cursor update (adds and compares per axis) done in the accepting cycle
// a two-entry output stage (result register plus skid register) keeps req ready while a
// brick word waits; rst (synchronous) sets cursors to zero, sizes to one, empties the stage
module volume_brick_tiler_core
  import vbt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  vbt_cfg_if.sink           cfg,
  vbt_req_if.sink           req,
  vbt_brick_if.source       brick
);

  // volume sizes
  logic [DIM_W-1:0] x_size;
  logic [DIM_W-1:0] y_size;
  logic [DIM_W-1:0] z_size;

  // scan state
  logic [DIM_W-1:0] x_cursor;
  logic [DIM_W-1:0] y_cursor;
  logic [DIM_W-1:0] z_cursor;
  logic             scan_done;

  // output stage
  vbt_brick_t out_word;
  vbt_brick_t skid_word;
  logic       out_valid;
  logic       skid_valid;

  // round a remainder of 1..BRICK_SIZE-1 up to a power of two
  function automatic logic [TEX_W-1:0] pow2_ceil(input logic [BRICK_LOG-1:0] v);
    logic [BRICK_LOG-1:0] d;
    logic [TEX_W-1:0]     res;
    d   = v - BRICK_LOG'(1);
    res = TEX_W'(1);
    for (int i = 0; i < BRICK_LOG; i++) begin
      if (d[i]) begin
        res = TEX_W'(1) << (i + 1);
      end
    end
    return res;
  endfunction

  // one axis of the brick at cursor c in a volume edge of n voxels (c < n)
  function automatic vbt_axis_t axis_brick(input logic [DIM_W-1:0] c,
                                           input logic [DIM_W-1:0] n);
    logic [DIM_W:0] tex_start;
    logic [DIM_W:0] limit;
    logic [DIM_W:0] rem;
    logic [DIM_W:0] n_wide;
    logic           inner;
    vbt_axis_t      a;
    n_wide    = {1'b0, n};
    // texture starts OVERLAP voxels early only when the cursor lies above OVERLAP
    tex_start = (c > DIM_W'(OVERLAP)) ? ({1'b0, c} - (DIM_W+1)'(OVERLAP)) : {1'b0, c};
    limit     = tex_start + (DIM_W+1)'(BRICK_SIZE);
    rem       = n_wide - tex_start;
    // a full brick that stops short of the edge gives up its overlap at the end
    inner     = limit < n_wide;
    a.extent  = (limit > n_wide) ? pow2_ceil(rem[BRICK_LOG-1:0]) : TEX_W'(BRICK_SIZE);
    a.stop    = inner ? DIM_W'(limit - (DIM_W+1)'(1 + OVERLAP)) : (n - DIM_W'(1));
    a.wrap    = !inner;
    return a;
  endfunction

  // configuration writes, taken at any time
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_size <= DIM_W'(1);
      y_size <= DIM_W'(1);
      z_size <= DIM_W'(1);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_X_SIZE: x_size <= cfg.data;
        REG_Y_SIZE: y_size <= cfg.data;
        REG_Z_SIZE: z_size <= cfg.data;
        default: ;
      endcase
    end
  end

  // brick computation from the current cursors
  logic             accept;
  logic [DIM_W-1:0] cx;
  logic [DIM_W-1:0] cy;
  logic [DIM_W-1:0] cz;
  logic             done_eff;
  logic             finished;
  vbt_axis_t        ax;
  vbt_axis_t        ay;
  vbt_axis_t        az;
  logic             last;
  vbt_brick_t       result;
  logic [DIM_W-1:0] x_cursor_next;
  logic [DIM_W-1:0] y_cursor_next;
  logic [DIM_W-1:0] z_cursor_next;
  logic             scan_done_next;

  assign req.ready = !skid_valid;
  assign accept    = req.valid && req.ready;

  always_comb begin
    // restart puts the walk back at the origin before this word is served
    cx       = req.restart ? '0 : x_cursor;
    cy       = req.restart ? '0 : y_cursor;
    cz       = req.restart ? '0 : z_cursor;
    done_eff = req.restart ? 1'b0 : scan_done;
    // finished scan, empty volume, or sizes shrunk under the cursors
    finished = done_eff || (cx >= x_size) || (cy >= y_size) || (cz >= z_size);

    ax   = axis_brick(cx, x_size);
    ay   = axis_brick(cy, y_size);
    az   = axis_brick(cz, z_size);
    last = ax.wrap && ay.wrap && az.wrap;

    if (finished) begin
      result         = '0;
      x_cursor_next  = cx;
      y_cursor_next  = cy;
      z_cursor_next  = cz;
      scan_done_next = 1'b1;
    end else begin
      result.brick_valid = 1'b1;
      result.x_lo        = cx;
      result.x_hi        = ax.stop;
      result.y_lo        = cy;
      result.y_hi        = ay.stop;
      result.z_lo        = cz;
      result.z_hi        = az.stop;
      result.tex_x       = ax.extent;
      result.tex_y       = ay.extent;
      result.tex_z       = az.extent;
      result.last_brick  = last;
      // x steps fastest, y on an x wrap, z on a y wrap
      x_cursor_next  = ax.wrap ? '0 : (ax.stop + DIM_W'(1));
      y_cursor_next  = !ax.wrap ? cy : (ay.wrap ? '0 : (ay.stop + DIM_W'(1)));
      z_cursor_next  = !(ax.wrap && ay.wrap) ? cz : (az.wrap ? '0 : (az.stop + DIM_W'(1)));
      scan_done_next = last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_cursor  <= '0;
      y_cursor  <= '0;
      z_cursor  <= '0;
      scan_done <= 1'b0;
    end else if (accept) begin
      x_cursor  <= x_cursor_next;
      y_cursor  <= y_cursor_next;
      z_cursor  <= z_cursor_next;
      scan_done <= scan_done_next;
    end
  end

  // output stage: result register fed by the skid register or straight from the logic
  logic out_free;
  assign out_free = !out_valid || brick.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= accept;
      end else begin
        out_valid  <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_word <= skid_word;
        if (accept) begin
          skid_word <= result;
        end
      end else if (accept) begin
        out_word <= result;
      end
    end else if (accept) begin
      skid_word <= result;
    end
  end

  assign brick.valid       = out_valid;
  assign brick.brick_valid = out_word.brick_valid;
  assign brick.x_lo        = out_word.x_lo;
  assign brick.x_hi        = out_word.x_hi;
  assign brick.y_lo        = out_word.y_lo;
  assign brick.y_hi        = out_word.y_hi;
  assign brick.z_lo        = out_word.z_lo;
  assign brick.z_hi        = out_word.z_hi;
  assign brick.tex_x       = out_word.tex_x;
  assign brick.tex_y       = out_word.tex_y;
  assign brick.tex_z       = out_word.tex_z;
  assign brick.last_brick  = out_word.last_brick;

endmodule
